// ===== design/rpsu_pkg.sv =====
// ----------------------------------------------------------------------------
// rpsu_pkg
// Shared types and constants of the register pair and stack unit.
// ----------------------------------------------------------------------------
package rpsu_pkg;

	localparam int ADDRESS_BITS_DEF = 16;

	typedef enum logic [3:0] {
		CMD_PUSH     = 4'd0,
		CMD_POP      = 4'd1,
		CMD_DAD      = 4'd2,
		CMD_INX      = 4'd3,
		CMD_DCX      = 4'd4,
		CMD_XCHG     = 4'd5,
		CMD_XTHL     = 4'd6,
		CMD_SPHL     = 4'd7,
		CMD_LOADPAIR = 4'd8,
		CMD_MEMWRITE = 4'd9,
		CMD_MEMREAD  = 4'd10,
		CMD_LOADPSW  = 4'd11
	} command_t;

	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_A0,
		ST_A1,
		ST_A2,
		ST_A3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] pair_bc;
		logic [15:0] pair_de;
		logic [15:0] pair_hl;
		logic [15:0] stack_top;
		logic [15:0] instr_address;
		logic [7:0]  acc_value;
		logic [7:0]  status_byte;
		logic [7:0]  read_byte;
	} res_t;

endpackage

// ===== design/rpsu_req_if.sv =====
// ----------------------------------------------------------------------------
// rpsu_req_if
// Command channel: one item carries a command and its operands.
// ----------------------------------------------------------------------------
interface rpsu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [1:0]  pair;
	logic [15:0] address;
	logic [15:0] value;

	modport source (output valid, output command, output pair, output address,
		output value, input ready);
	modport sink (input valid, input command, input pair, input address,
		input value, output ready);
endinterface

// ===== design/rpsu_res_if.sv =====
// ----------------------------------------------------------------------------
// rpsu_res_if
// Result channel: one item reports all registers after a command.
// ----------------------------------------------------------------------------
interface rpsu_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] pair_bc;
	logic [15:0] pair_de;
	logic [15:0] pair_hl;
	logic [15:0] stack_top;
	logic [15:0] instr_address;
	logic [7:0]  acc_value;
	logic [7:0]  status_byte;
	logic [7:0]  read_byte;

	modport source (output valid, output pair_bc, output pair_de, output pair_hl,
		output stack_top, output instr_address, output acc_value,
		output status_byte, output read_byte, input ready);
	modport sink (input valid, input pair_bc, input pair_de, input pair_hl,
		input stack_top, input instr_address, input acc_value,
		input status_byte, input read_byte, output ready);
endinterface

// ===== design/rpsu_mem.sv =====
// ----------------------------------------------------------------------------
// rpsu_mem
// Single-port byte memory with a registered read port.
// ----------------------------------------------------------------------------
module rpsu_mem
	import rpsu_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic     clk,
	input  mem_req_t req,
	output logic [7:0] rdata
);

	logic [7:0] mem [2**ADDRESS_BITS];
	logic [ADDRESS_BITS-1:0] addr;

	assign addr = req.addr[ADDRESS_BITS-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== design/rpsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpsu_ctrl
// Sequencer and register file: runs the memory accesses of a command and
// commits the register updates.
// ----------------------------------------------------------------------------
module rpsu_ctrl
	import rpsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rpsu_req_if.sink   request,
	output mem_req_t   mem_req,
	input  logic [7:0] mem_rdata,
	input  logic       res_free,
	output logic       res_load,
	output res_t       res_data
);

	state_t state_q, state_d;

	command_t    cmd_q;
	logic [1:0]  pair_q;
	logic [15:0] addr_q;
	logic [15:0] value_q;
	logic [7:0]  lo_q, hi_q;

	logic [15:0] bc_q, de_q, hl_q, sp_q, pc_q;
	logic [7:0]  acc_q;
	logic [4:0]  flag_q;

	logic [15:0] bc_d, de_d, hl_d, sp_d, pc_d;
	logic [7:0]  acc_d, rd_d;
	logic [4:0]  flag_d;

	logic [15:0] sel_pair, push_word, step_word;
	logic [16:0] dad_sum;
	logic        accept, cap_lo, cap_hi;

	function automatic logic [7:0] pack_flags(input logic [4:0] f);
		pack_flags = {f[4], f[3], 1'b0, f[2], 1'b0, f[1], 1'b1, f[0]};
	endfunction

	function automatic logic [4:0] unpack_flags(input logic [7:0] b);
		unpack_flags = {b[7], b[6], b[4], b[2], b[0]};
	endfunction

	function automatic logic is_mem_cmd(input command_t c);
		is_mem_cmd = (c == CMD_PUSH) || (c == CMD_POP) || (c == CMD_XTHL) ||
			(c == CMD_MEMWRITE) || (c == CMD_MEMREAD);
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (request.valid) begin
					state_d = is_mem_cmd(command_t'(request.command)) ? ST_A0 : ST_DONE;
				end
			end
			ST_A0: state_d = (cmd_q == CMD_MEMWRITE) ? ST_DONE : ST_A1;
			ST_A1: state_d = (cmd_q == CMD_PUSH || cmd_q == CMD_MEMREAD) ? ST_DONE : ST_A2;
			ST_A2: state_d = (cmd_q == CMD_POP) ? ST_DONE : ST_A3;
			ST_A3: state_d = ST_DONE;
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (pair_q)
			PAIR_BC: sel_pair = bc_q;
			PAIR_DE: sel_pair = de_q;
			PAIR_HL: sel_pair = hl_q;
			default: sel_pair = sp_q;
		endcase
		push_word = (pair_q == PAIR_SP) ? {acc_q, pack_flags(flag_q)} : sel_pair;
	end

	always_comb begin
		request.ready = 1'b0;
		mem_req       = '{we: 1'b0, addr: sp_q, wdata: 8'h00};
		cap_lo        = 1'b0;
		cap_hi        = 1'b0;
		res_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: request.ready = 1'b1;
			ST_A0: begin
				unique case (cmd_q)
					CMD_PUSH: mem_req = '{we: 1'b1, addr: sp_q - 16'd1, wdata: push_word[15:8]};
					CMD_MEMWRITE: mem_req = '{we: 1'b1, addr: addr_q, wdata: value_q[7:0]};
					CMD_MEMREAD: mem_req = '{we: 1'b0, addr: addr_q, wdata: 8'h00};
					default: mem_req = '{we: 1'b0, addr: sp_q, wdata: 8'h00};
				endcase
			end
			ST_A1: begin
				cap_lo = 1'b1;
				if (cmd_q == CMD_PUSH) begin
					mem_req = '{we: 1'b1, addr: sp_q - 16'd2, wdata: push_word[7:0]};
				end else begin
					mem_req = '{we: 1'b0, addr: sp_q + 16'd1, wdata: 8'h00};
				end
			end
			ST_A2: begin
				cap_hi  = 1'b1;
				mem_req = '{we: (cmd_q == CMD_XTHL), addr: sp_q, wdata: hl_q[7:0]};
			end
			ST_A3: mem_req = '{we: 1'b1, addr: sp_q + 16'd1, wdata: hl_q[15:8]};
			ST_DONE: res_load = res_free;
			default: request.ready = 1'b0;
		endcase
	end

	assign accept = request.valid && request.ready;

	always_comb begin
		bc_d      = bc_q;
		de_d      = de_q;
		hl_d      = hl_q;
		sp_d      = sp_q;
		acc_d     = acc_q;
		flag_d    = flag_q;
		rd_d      = 8'h00;
		step_word = sel_pair;
		dad_sum   = {1'b0, hl_q} + {1'b0, sel_pair};
		pc_d      = (cmd_q <= CMD_SPHL) ? pc_q + 16'd1 : pc_q;
		unique case (cmd_q)
			CMD_PUSH: sp_d = sp_q - 16'd2;
			CMD_POP: begin
				step_word = {hi_q, lo_q};
				sp_d      = sp_q + 16'd2;
			end
			CMD_DAD: begin
				hl_d      = dad_sum[15:0];
				flag_d[0] = dad_sum[16];
			end
			CMD_INX: step_word = sel_pair + 16'd1;
			CMD_DCX: step_word = sel_pair - 16'd1;
			CMD_XCHG: begin
				de_d = hl_q;
				hl_d = de_q;
			end
			CMD_XTHL: hl_d = {hi_q, lo_q};
			CMD_SPHL: sp_d = hl_q;
			CMD_LOADPAIR: step_word = value_q;
			CMD_MEMREAD: rd_d = lo_q;
			CMD_LOADPSW: begin
				acc_d  = value_q[15:8];
				flag_d = unpack_flags(value_q[7:0]);
			end
			default: rd_d = 8'h00;
		endcase
		if ((cmd_q == CMD_POP) && (pair_q == PAIR_SP)) begin
			acc_d  = hi_q;
			flag_d = unpack_flags(lo_q);
		end else if ((cmd_q == CMD_POP) || (cmd_q == CMD_INX) || (cmd_q == CMD_DCX) ||
				(cmd_q == CMD_LOADPAIR)) begin
			unique case (pair_q)
				PAIR_BC: bc_d = step_word;
				PAIR_DE: de_d = step_word;
				PAIR_HL: hl_d = step_word;
				default: sp_d = step_word;
			endcase
		end
		res_data = '{pair_bc: bc_d, pair_de: de_d, pair_hl: hl_d, stack_top: sp_d,
			instr_address: pc_d, acc_value: acc_d, status_byte: pack_flags(flag_d),
			read_byte: rd_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bc_q    <= '0;
			de_q    <= '0;
			hl_q    <= '0;
			sp_q    <= '0;
			pc_q    <= '0;
			acc_q   <= '0;
			flag_q  <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				bc_q   <= bc_d;
				de_q   <= de_d;
				hl_q   <= hl_d;
				sp_q   <= sp_d;
				pc_q   <= pc_d;
				acc_q  <= acc_d;
				flag_q <= flag_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command_t'(request.command);
			pair_q  <= request.pair;
			addr_q  <= request.address;
			value_q <= request.value;
		end
		if (cap_lo) begin
			lo_q <= mem_rdata;
		end
		if (cap_hi) begin
			hi_q <= mem_rdata;
		end
	end

endmodule

// ===== design/register_pair_stack_unit.sv =====
// ----------------------------------------------------------------------------
// register_pair_stack_unit
// Register pair and stack command group of an 8080-style core.
// ----------------------------------------------------------------------------
// One command is handled at a time; the single-port byte memory sets its
// length. A command that touches only registers goes from acceptance to the
// done state; memory write passes access state A0, read and push A0-A1, pop
// A0-A2 and XTHL A0-A3, one memory access per cycle, with registered reads.
// The result is loaded in the done state once the output register frees, and
// the next command is taken in the cycle after. The result sits in an output
// register, so the next command is taken while an earlier result still waits.
module register_pair_stack_unit
	import rpsu_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	rpsu_req_if.sink request,
	rpsu_res_if.source result
);

	mem_req_t   mem_req;
	logic [7:0] mem_rdata;
	logic       res_free, res_load, res_valid_q;
	res_t       res_data, res_q;

	rpsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_free  (res_free),
		.res_load  (res_load),
		.res_data  (res_data)
	);

	rpsu_mem #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign res_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_data;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.pair_bc       = res_q.pair_bc;
	assign result.pair_de       = res_q.pair_de;
	assign result.pair_hl       = res_q.pair_hl;
	assign result.stack_top     = res_q.stack_top;
	assign result.instr_address = res_q.instr_address;
	assign result.acc_value     = res_q.acc_value;
	assign result.status_byte   = res_q.status_byte;
	assign result.read_byte     = res_q.read_byte;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the register pair and stack unit and checks
// every result item, all registers and the read byte, against an in-bench
// model of the register file, flags, stack pointer, program counter and
// memory. Directed items cover the corner cases; random phases mix stack
// sequences, register commands and memory traffic under idle, stall and
// long back-pressure conditions.
// ----------------------------------------------------------------------------
module testbench
	import rpsu_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_BITS = ADDRESS_BITS_DEF;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam logic [3:0] CMD_UNUSED_FIRST = 4'd12;
	localparam logic [3:0] CMD_UNUSED_LAST = 4'd15;
	localparam logic [7:0] FLAG_KEEP = 8'hD5;
	localparam logic [7:0] FLAG_FIXED = 8'h02;
	localparam logic [7:0] CARRY_BIT = 8'h01;

	typedef struct packed {
		logic [3:0]  command;
		logic [1:0]  pair;
		logic [15:0] address;
		logic [15:0] value;
	} cmd_item_t;

	logic clk = 1'b0;
	logic arst_n;

	rpsu_req_if req_ch ();
	rpsu_res_if res_ch ();

	register_pair_stack_unit #(.ADDRESS_BITS(ADDR_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(res_ch)
	);

	always #5 clk = ~clk;

	logic [15:0] pair_val [3] = '{default: 16'h0000};
	logic [15:0] sp_val = 16'h0000;
	logic [15:0] pc_val = 16'h0000;
	logic [7:0]  acc_val = 8'h00;
	logic [7:0]  psw_val = FLAG_FIXED;
	logic [7:0]  mem_image [int];

	res_t expected_results [$];
	res_t due;
	int   mismatches = 0;
	int   items_sent = 0;
	int   results_seen = 0;
	int   cmd_count [16] = '{default: 0};
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   hold_start = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	function automatic int mem_index(logic [15:0] a);
		return int'(a) & ((1 << ADDR_BITS) - 1);
	endfunction

	function automatic logic [7:0] load_byte(logic [15:0] a);
		return mem_image.exists(mem_index(a)) ? mem_image[mem_index(a)] : 8'h00;
	endfunction

	function automatic void store_byte(logic [15:0] a, logic [7:0] v);
		mem_image[mem_index(a)] = v;
	endfunction

	function automatic logic [15:0] read_pair(logic [1:0] p);
		return (p == PAIR_SP) ? sp_val : pair_val[p];
	endfunction

	function automatic void write_pair(logic [1:0] p, logic [15:0] v);
		if (p == PAIR_SP) begin
			sp_val = v;
		end else begin
			pair_val[p] = v;
		end
	endfunction

	function automatic logic [7:0] normalize_flags(logic [7:0] b);
		return (b & FLAG_KEEP) | FLAG_FIXED;
	endfunction

	function automatic res_t execute_command(cmd_item_t it);
		res_t        r;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] w;
		logic [16:0] sum;
		logic        steps_pc;
		r = '0;
		steps_pc = 1'b1;
		case (it.command)
			CMD_PUSH: begin
				w = (it.pair == PAIR_SP) ? {acc_val, psw_val} : pair_val[it.pair];
				store_byte(sp_val - 16'd1, w[15:8]);
				store_byte(sp_val - 16'd2, w[7:0]);
				sp_val = sp_val - 16'd2;
			end
			CMD_POP: begin
				lo = load_byte(sp_val);
				hi = load_byte(sp_val + 16'd1);
				if (it.pair == PAIR_SP) begin
					acc_val = hi;
					psw_val = normalize_flags(lo);
				end else begin
					pair_val[it.pair] = {hi, lo};
				end
				sp_val = sp_val + 16'd2;
			end
			CMD_DAD: begin
				sum = {1'b0, pair_val[PAIR_HL]} + {1'b0, read_pair(it.pair)};
				psw_val = sum[16] ? (psw_val | CARRY_BIT) : (psw_val & ~CARRY_BIT);
				pair_val[PAIR_HL] = sum[15:0];
			end
			CMD_INX: write_pair(it.pair, read_pair(it.pair) + 16'd1);
			CMD_DCX: write_pair(it.pair, read_pair(it.pair) - 16'd1);
			CMD_XCHG: begin
				w = pair_val[PAIR_DE];
				pair_val[PAIR_DE] = pair_val[PAIR_HL];
				pair_val[PAIR_HL] = w;
			end
			CMD_XTHL: begin
				lo = load_byte(sp_val);
				hi = load_byte(sp_val + 16'd1);
				store_byte(sp_val, pair_val[PAIR_HL][7:0]);
				store_byte(sp_val + 16'd1, pair_val[PAIR_HL][15:8]);
				pair_val[PAIR_HL] = {hi, lo};
			end
			CMD_SPHL: sp_val = pair_val[PAIR_HL];
			CMD_LOADPAIR: begin
				write_pair(it.pair, it.value);
				steps_pc = 1'b0;
			end
			CMD_MEMWRITE: begin
				store_byte(it.address, it.value[7:0]);
				steps_pc = 1'b0;
			end
			CMD_MEMREAD: begin
				r.read_byte = load_byte(it.address);
				steps_pc = 1'b0;
			end
			CMD_LOADPSW: begin
				acc_val = it.value[15:8];
				psw_val = normalize_flags(it.value[7:0]);
				steps_pc = 1'b0;
			end
			default: steps_pc = 1'b0;
		endcase
		if (steps_pc) begin
			pc_val = pc_val + 16'd1;
		end
		r.pair_bc = pair_val[PAIR_BC];
		r.pair_de = pair_val[PAIR_DE];
		r.pair_hl = pair_val[PAIR_HL];
		r.stack_top = sp_val;
		r.instr_address = pc_val;
		r.acc_value = acc_val;
		r.status_byte = psw_val;
		return r;
	endfunction

	function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%t: result %0d field %s expected %h, got %h",
					$realtime, results_seen, field, want, got);
			end
		end
	endfunction

	function automatic cmd_item_t make_item(logic [3:0] c, logic [1:0] p, logic [15:0] a,
			logic [15:0] v);
		cmd_item_t it;
		it.command = c;
		it.pair = p;
		it.address = a;
		it.value = v;
		return it;
	endfunction

	function automatic logic [15:0] corner_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001;
			3: return 16'hFFFE;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic offer_item(input cmd_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= it.command;
		req_ch.pair <= it.pair;
		req_ch.address <= it.address;
		req_ch.value <= it.value;
		do @(posedge clk); while (!req_ch.ready);
		expected_results.push_back(execute_command(it));
		items_sent++;
		cmd_count[it.command]++;
	endtask

	// Bytes that a command will read are written first when they hold nothing yet.
	task automatic send_command(input cmd_item_t it);
		logic [15:0] reads [$];
		if (it.command == CMD_POP || it.command == CMD_XTHL) begin
			reads = '{sp_val, sp_val + 16'd1};
		end else if (it.command == CMD_MEMREAD) begin
			reads = '{it.address};
		end
		foreach (reads[i]) begin
			if (!mem_image.exists(mem_index(reads[i]))) begin
				offer_item(make_item(CMD_MEMWRITE, 2'($urandom), reads[i], 16'($urandom)));
			end
		end
		offer_item(it);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic cmd_item_t random_register_command();
		logic [3:0] c;
		case ($urandom_range(9))
			0: c = CMD_DAD;
			1: c = CMD_INX;
			2: c = CMD_DCX;
			3: c = CMD_XCHG;
			4: c = CMD_SPHL;
			5: c = CMD_LOADPAIR;
			6: c = CMD_LOADPSW;
			7: c = CMD_PUSH;
			8: c = CMD_POP;
			default: c = CMD_XTHL;
		endcase
		return make_item(c, 2'($urandom), 16'($urandom), corner_word());
	endfunction

	task automatic stack_sequence();
		int depth;
		int pops;
		depth = $urandom_range(1, 6);
		pops = depth;
		if ($urandom_range(3) == 0) begin
			pops = $urandom_range(0, depth + 1);
		end
		if ($urandom_range(1) == 1) begin
			send_command(make_item(CMD_LOADPAIR, PAIR_SP, 16'($urandom), corner_word()));
		end
		repeat (depth) begin
			if ($urandom_range(2) == 0) begin
				send_command(make_item(CMD_LOADPAIR, 2'($urandom_range(0, 2)), 16'($urandom),
					16'($urandom)));
			end
			send_command(make_item(CMD_PUSH, 2'($urandom), 16'($urandom), 16'($urandom)));
		end
		if ($urandom_range(2) == 0) begin
			send_command(make_item(CMD_XTHL, 2'($urandom), 16'($urandom), 16'($urandom)));
		end
		repeat (pops) begin
			send_command(make_item(CMD_POP, 2'($urandom), 16'($urandom), 16'($urandom)));
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		send_command(make_item(CMD_LOADPAIR, PAIR_BC, 16'h0000, 16'hFFFF));
		send_command(make_item(CMD_LOADPAIR, PAIR_DE, 16'hFFFF, 16'h0000));
		send_command(make_item(CMD_LOADPAIR, PAIR_HL, 16'h0000, 16'hFFFF));
		send_command(make_item(CMD_LOADPAIR, PAIR_SP, 16'hFFFF, 16'h0000));
		send_command(make_item(CMD_LOADPSW, PAIR_BC, 16'h0000, 16'hFFFF));
		send_command(make_item(CMD_PUSH, PAIR_SP, 16'h0000, 16'h0000));
		send_command(make_item(CMD_PUSH, PAIR_BC, 16'h0000, 16'h0000));
		send_command(make_item(CMD_DAD, PAIR_BC, 16'h0000, 16'h0000));
		send_command(make_item(CMD_DAD, PAIR_SP, 16'h0000, 16'h0000));
		send_command(make_item(CMD_DAD, PAIR_HL, 16'h0000, 16'h0000));
		send_command(make_item(CMD_INX, PAIR_BC, 16'h0000, 16'h0000));
		send_command(make_item(CMD_DCX, PAIR_BC, 16'h0000, 16'h0000));
		send_command(make_item(CMD_DCX, PAIR_SP, 16'h0000, 16'h0000));
		send_command(make_item(CMD_INX, PAIR_SP, 16'h0000, 16'h0000));
		send_command(make_item(CMD_XCHG, PAIR_SP, 16'hFFFF, 16'hFFFF));
		send_command(make_item(CMD_XTHL, PAIR_DE, 16'hFFFF, 16'hFFFF));
		send_command(make_item(CMD_POP, PAIR_DE, 16'h0000, 16'h0000));
		send_command(make_item(CMD_LOADPSW, PAIR_SP, 16'hFFFF, 16'h0000));
		send_command(make_item(CMD_POP, PAIR_SP, 16'h0000, 16'h0000));
		send_command(make_item(CMD_MEMWRITE, PAIR_SP, 16'h0000, 16'hFF5A));
		send_command(make_item(CMD_MEMREAD, PAIR_HL, 16'hFFFF, 16'hFFFF));
		send_command(make_item(CMD_MEMREAD, PAIR_BC, 16'h0000, 16'h0000));
		send_command(make_item(CMD_LOADPAIR, PAIR_SP, 16'h0000, 16'hFFFF));
		send_command(make_item(CMD_POP, PAIR_BC, 16'h0000, 16'h0000));
		send_command(make_item(CMD_SPHL, PAIR_DE, 16'h0000, 16'h0000));
		send_command(make_item(CMD_UNUSED_FIRST, PAIR_BC, 16'h0000, 16'hFFFF));
		send_command(make_item(CMD_UNUSED_LAST, PAIR_SP, 16'hFFFF, 16'h0000));
		wait_for_results();
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall);
		int first;
		int kind;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		first = items_sent;
		while (items_sent - first < count) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				stack_sequence();
			end else if (kind < 80) begin
				send_command(random_register_command());
			end else if (kind < 97) begin
				send_command(make_item($urandom_range(1) ? CMD_MEMWRITE : CMD_MEMREAD,
					2'($urandom), corner_word(), 16'($urandom)));
			end else begin
				send_command(make_item(4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
					2'($urandom), 16'($urandom), 16'($urandom)));
			end
		end
		wait_for_results();
	endtask

	// The receiver holds off while the sender keeps offering, so the unit fills up.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_start = HOLD_CYCLES;
		repeat (24) begin
			send_command(random_register_command());
		end
		wait_for_results();
	endtask

	task automatic finish_run();
		int unused_count;
		unused_count = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += expected_results.size();
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
			unused_count += cmd_count[c];
		end
		$display("Sent %0d command items (%0d stack, %0d memory, %0d unused codes).",
			items_sent,
			cmd_count[CMD_PUSH] + cmd_count[CMD_POP] + cmd_count[CMD_XTHL] + cmd_count[CMD_SPHL],
			cmd_count[CMD_MEMWRITE] + cmd_count[CMD_MEMREAD],
			unused_count);
		$display("Checked %0d result items over four idle/stall mixes and one long hold-off.",
			results_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%t: result item with nothing expected", $realtime);
				end
			end else begin
				due = expected_results.pop_front();
				compare_field("pair_bc", due.pair_bc, res_ch.pair_bc);
				compare_field("pair_de", due.pair_de, res_ch.pair_de);
				compare_field("pair_hl", due.pair_hl, res_ch.pair_hl);
				compare_field("stack_top", due.stack_top, res_ch.stack_top);
				compare_field("instr_address", due.instr_address, res_ch.instr_address);
				compare_field("acc_value", due.acc_value, res_ch.acc_value);
				compare_field("status_byte", due.status_byte, res_ch.status_byte);
				compare_field("read_byte", due.read_byte, res_ch.read_byte);
			end
		end
		if (hold_start > 0) begin
			hold_left = hold_start;
			hold_start = 0;
		end
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_PUSH;
		req_ch.pair = PAIR_BC;
		req_ch.address = 16'h0000;
		req_ch.value = 16'h0000;
		res_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500, 0, 0);
		test_random(500, 50, 0);
		test_random(500, 0, 50);
		test_random(500, 38, 38);
		test_backpressure();
		finish_run();
	end

endmodule

// ===== sim.f =====
design/rpsu_pkg.sv
design/rpsu_req_if.sv
design/rpsu_res_if.sv
design/rpsu_mem.sv
design/rpsu_ctrl.sv
design/register_pair_stack_unit.sv
verif/testbench.sv
